FILE: rtl/pbts_pkg.sv
// Package for the packet bit-transpose scrambler.
// Holds the shared constants, the burst type and the 8x8 bit transpose function.
// No dependencies.
`default_nettype none

package pbts_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int BYTE_W      = 8;
    localparam int BLOCK_W     = BLOCK_BYTES * BYTE_W;
    localparam int BURST_W     = 2 * BLOCK_W;
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = 3;
    localparam int APB_DW      = 32;

    localparam logic [2:0]        LAST_FILL      = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_DIRECTION = 3'd0;

    typedef enum logic {
        DIR_SCRAMBLE   = 1'b0,
        DIR_DESCRAMBLE = 1'b1
    } t_dir;

    // One burst of results from a single request, byte 0 in the low bits.
    typedef struct packed {
        logic [BURST_W-1:0] data;
        logic [CNT_W-1:0]   count;
        logic               pkt_end;
    } t_burst;

    // Bit i of byte j moves to bit j of byte i.
    function automatic logic [BLOCK_W-1:0] f_transpose(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            for (int j = 0; j < BLOCK_BYTES; j++) begin
                y[BYTE_W*i+j] = x[BYTE_W*j+i];
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/packet_bit_transpose_scrambler_core.sv
// Top level of the packet bit-transpose scrambler.
// Depends on pbts_pkg, pbts_regs, pbts_engine and pbts_out_buf.
//
//   Channel   Dir  Handshake          Payload
//   s_axis    in   tvalid / tready    tdata[7:0] data_byte, tlast last_byte
//   m_axis    out  tvalid / tready    tdata[7:0] out_byte, tuser run_end, tlast packet_end
//   apb       in   psel/penable/pready  reg 0 at 0x0: direction (0 scramble, 1 descramble)
//
// Flow: one request per cycle unless stalled as below. A request lands in the input register,
// then combinational logic builds its result burst (0, r, 8, 8+r or 16 bytes) into
// the burst register, which sends one byte per cycle while m_axis_tready is high.
// Stalls: a request that yields bytes waits in the input register until the burst
// register is empty or sends its final byte in the same cycle; requests that only
// fill a block move on at once.
// Reset (synchronous, active low) clears control state and sets direction to scramble.
`default_nettype none

module packet_bit_transpose_scrambler_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
    input  wire logic                        s_axis_tlast,  // last_byte
    // result stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [7:0]                  m_axis_tdata,  // [7:0] out_byte
    output logic                             m_axis_tuser,  // run_end
    output logic                             m_axis_tlast,  // packet_end
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pbts_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pbts_pkg::APB_DW-1:0] pwdata,
    output logic      [pbts_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import pbts_pkg::*;

    t_dir   dir;
    logic   buf_free;
    logic   load;
    t_burst burst;

    // Direction register.
    pbts_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_dir     (dir)
    );

    // Hold the request, track partial and held blocks, build the result burst.
    pbts_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dir      (dir),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_buf_free (buf_free),
        .o_load     (load),
        .o_burst    (burst)
    );

    // Drain the burst one byte per accepted result.
    pbts_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_burst   (burst),
        .o_free    (buf_free),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_run_end (m_axis_tuser),
        .o_pkt_end (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/pbts_regs.sv
// Configuration register file (direction) behind an APB-style port.
// Depends on pbts_pkg.
`default_nettype none

module pbts_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [pbts_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [pbts_pkg::APB_DW-1:0] i_pwdata,
    output logic      [pbts_pkg::APB_DW-1:0] o_prdata,
    output logic                             o_pready,
    output pbts_pkg::t_dir                   o_dir
);
    import pbts_pkg::*;

    t_dir r_dir;
    t_dir n_dir;
    logic wr_dir;

    assign o_pready = 1'b1;
    assign wr_dir   = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_DIRECTION);

    always_comb begin
        n_dir = r_dir;
        if (wr_dir) begin
            n_dir = t_dir'(i_pwdata[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_SCRAMBLE;
        end else begin
            r_dir <= n_dir;
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr == ADDR_DIRECTION) begin
            o_prdata = {{(APB_DW-1){1'b0}}, r_dir};
        end
    end

    assign o_dir = r_dir;

endmodule

`default_nettype wire

FILE: rtl/pbts_engine.sv
// Input register, packet state (partial and held blocks) and burst builder.
// Depends on pbts_pkg.
`default_nettype none

module pbts_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pbts_pkg::t_dir              i_dir,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [pbts_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_last,
    input  wire logic                        i_buf_free,
    output logic                             o_load,
    output pbts_pkg::t_burst                 o_burst
);
    import pbts_pkg::*;

    // input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // packet state
    logic [BYTE_W-1:0]  r_part [0:BLOCK_BYTES-2];
    logic [2:0]         r_fill;
    logic [BLOCK_W-1:0] r_held;
    logic               r_held_vld;

    logic                  advance;
    logic                  block_done;
    logic [BLOCK_W-8-1:0]  part_vec;
    logic [BLOCK_W-1:0]    blk;
    logic [BLOCK_W-1:0]    tail;
    logic [2:0]            tail_len;
    logic [5:0]            sh_r;
    logic [5:0]            sh_nr;
    logic [BLOCK_W-1:0]    low_mask;
    logic [BLOCK_W-1:0]    held_t;
    logic [BLOCK_W-1:0]    win;
    logic [BLOCK_W-1:0]    win_t;
    logic [BLOCK_W-1:0]    comb_c;
    t_burst                burst;

    always_comb begin
        for (int k = 0; k < BLOCK_BYTES - 1; k++) begin
            part_vec[BYTE_W*k +: BYTE_W] = r_part[k];
        end
    end

    assign block_done = (r_fill == LAST_FILL);
    assign blk        = {r_in_byte, part_vec};
    assign tail_len   = r_fill + 3'd1;
    assign sh_r       = {tail_len, 3'b000};
    assign sh_nr      = {3'd0 - tail_len, 3'b000};
    assign low_mask   = ~({BLOCK_W{1'b1}} << sh_r);
    assign held_t     = f_transpose(r_held);

    always_comb begin
        tail = {{BYTE_W{1'b0}}, part_vec};
        tail[{r_fill, 3'b000} +: BYTE_W] = r_in_byte;
    end

    // Overlap window over the last eight bytes; it is cut from the transposed
    // held block when scrambling and from the raw held block when descrambling.
    always_comb begin
        if (i_dir == DIR_SCRAMBLE) begin
            win = (held_t >> sh_r) | (tail << sh_nr);
        end else begin
            win = (r_held >> sh_r) | (tail << sh_nr);
        end
    end
    assign win_t  = f_transpose(win);
    assign comb_c = (r_held & low_mask) | (win_t << sh_r);

    always_comb begin
        burst.data    = '0;
        burst.count   = '0;
        burst.pkt_end = r_in_last;
        if (block_done) begin
            if (r_held_vld) begin
                burst.data  = {f_transpose(blk), held_t};
                burst.count = r_in_last ? CNT_W'(2 * BLOCK_BYTES) : CNT_W'(BLOCK_BYTES);
            end else begin
                burst.data  = {{BLOCK_W{1'b0}}, f_transpose(blk)};
                burst.count = r_in_last ? CNT_W'(BLOCK_BYTES) : '0;
            end
        end else if (r_in_last) begin
            if (!r_held_vld) begin
                burst.data  = {{BLOCK_W{1'b0}}, tail};
                burst.count = CNT_W'(tail_len);
            end else begin
                burst.count = CNT_W'(BLOCK_BYTES) + CNT_W'(tail_len);
                if (i_dir == DIR_SCRAMBLE) begin
                    burst.data = {{BLOCK_W{1'b0}}, held_t & low_mask}
                               | ({{BLOCK_W{1'b0}}, win_t} << sh_r);
                end else begin
                    burst.data = {win_t >> sh_nr, f_transpose(comb_c)};
                end
            end
        end
    end

    // Requests that give no result advance even while the output drains.
    assign advance = r_in_vld && ((burst.count == '0) || i_buf_free);
    assign o_ready = !r_in_vld || advance;
    assign o_load  = advance && (burst.count != '0);
    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_fill     <= '0;
            r_held_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                if (block_done) begin
                    r_fill     <= '0;
                    r_held_vld <= !r_in_last;
                end else begin
                    r_fill <= r_in_last ? 3'd0 : r_fill + 3'd1;
                    if (r_in_last) begin
                        r_held_vld <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
        if (advance) begin
            if (block_done) begin
                r_held <= blk;
            end else begin
                r_part[r_fill] <= r_in_byte;
            end
        end
    end

    a_pkt_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_fill == '0 && !r_held_vld))
        else $error("packet state not cleared after packet end");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |-> o_load)
        else $error("packet end produced no output burst");

endmodule

`default_nettype wire

FILE: rtl/pbts_out_buf.sv
// Output burst register: holds up to 16 result bytes and sends one per cycle while i_ready is high.
// Depends on pbts_pkg.
`default_nettype none

module pbts_out_buf (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire pbts_pkg::t_burst       i_burst,
    output logic                        o_free,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [pbts_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_run_end,
    output logic                        o_pkt_end
);
    import pbts_pkg::*;

    logic [BURST_W-1:0] r_data;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pkt_end;
    logic               take;

    assign o_valid   = (r_cnt != '0);
    assign take      = o_valid && i_ready;
    assign o_free    = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_ready);
    assign o_byte    = r_data[BYTE_W-1:0];
    assign o_run_end = (r_cnt == CNT_W'(1));
    assign o_pkt_end = (r_cnt == CNT_W'(1)) && r_pkt_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data    <= i_burst.data;
            r_pkt_end <= i_burst.pkt_end;
        end else if (take) begin
            r_data <= r_data >> BYTE_W;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("burst loaded over undelivered results");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(2 * BLOCK_BYTES))
        else $error("burst count out of range");

endmodule

`default_nettype wire
